// ----- rtl/trial_division_prime_test_assert.svh -----
// Assertion macros used by trial_division_prime_test.sv.
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define TDP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the cycle after.
`define TDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tdp_pkg.sv -----
`default_nettype none

package tdp_pkg;

  localparam int NumWidth = 32;
  // Magnitude of a non-negative value, sign bit dropped.
  localparam int MagWidth = NumWidth - 1;
  // Trial divisors tried never exceed the square root of the magnitude.
  localparam int DivWidth = (NumWidth + 1) / 2;
  localparam int SqWidth  = NumWidth;
  localparam int CntWidth = $clog2(MagWidth);

  localparam int FirstDivisor = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

`default_nettype wire

// ----- rtl/tdp_div.sv -----
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module tdp_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [tdp_pkg::MagWidth-1:0]   dividend_i,
  input  wire logic [tdp_pkg::DivWidth-1:0]   divisor_i,
  output tdp_pkg::div_status_t                status_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [tdp_pkg::CntWidth-1:0]   cnt_q, cnt_d;
  logic [tdp_pkg::MagWidth-1:0]   dvd_q, dvd_d;
  logic [tdp_pkg::DivWidth-1:0]   div_q, div_d;
  logic [tdp_pkg::DivWidth:0]     rem_q, rem_d;

  logic [tdp_pkg::DivWidth:0]     rem_shift;
  logic [tdp_pkg::DivWidth:0]     div_ext;
  logic                           last_bit;

  always_comb begin
    rem_shift = {rem_q[tdp_pkg::DivWidth-1:0], dvd_q[tdp_pkg::MagWidth-1]};
    div_ext   = {1'b0, div_q};
    last_bit  = (cnt_q == tdp_pkg::CntWidth'(tdp_pkg::MagWidth - 1));

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // bring down the next bit, subtract when it fits
      rem_d = (rem_shift >= div_ext) ? (rem_shift - div_ext) : rem_shift;
      dvd_d = {dvd_q[tdp_pkg::MagWidth-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (last_bit) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

// ----- rtl/trial_division_prime_test.sv -----
`default_nettype none
// Trial-division primality test.
// Input channel: in_valid_i / in_ready_o carry one signed value_i word.
// Output channel: out_valid_o / out_ready_i carry one is_prime_o word per input.
// Negative values, zero and one finish at once and report not prime.
// Otherwise divisors d = 2, 3, ... are tried while d*d <= value; d*d is kept
// as a running sum, so no multiplier is needed. Each divisor costs one bound
// check plus one pass of the shared bit-serial remainder unit. A 31-bit prime
// needs up to 46339 divisors tried.
// One word is worked on at a time; in_ready_o is high only while idle.
// A finished result sits in an output register, so a new word can be taken
// while the receiver stalls; the block then waits at the end of that word
// until the register frees up.
// Reset clears the sequencer and drops any pending result.
module trial_division_prime_test (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tdp_pkg::NumWidth-1:0]  value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               is_prime_o
);

  tdp_pkg::state_e state_q, state_d;

  logic [tdp_pkg::MagWidth-1:0] n_q, n_d;
  logic [tdp_pkg::DivWidth-1:0] d_q, d_d;
  logic [tdp_pkg::SqWidth-1:0]  sq_q, sq_d;
  logic                         res_q, res_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_prime_q, out_prime_d;

  logic                         in_accept;
  logic                         too_small;
  logic                         in_bound;
  logic                         out_free;
  logic                         div_start;
  logic                         finish_load;
  tdp_pkg::div_status_t         div_status;

  assign in_accept = in_valid_i && in_ready_o;
  assign too_small = value_i[tdp_pkg::NumWidth-1] ||
                     (value_i[tdp_pkg::MagWidth-1:0] <
                      tdp_pkg::MagWidth'(tdp_pkg::FirstDivisor));
  assign in_bound  = (sq_q <= {1'b0, n_q});
  assign out_free  = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = too_small ? tdp_pkg::ST_FINISH : tdp_pkg::ST_CHECK;
        end
      end
      tdp_pkg::ST_CHECK: begin
        state_d = in_bound ? tdp_pkg::ST_DIV : tdp_pkg::ST_FINISH;
      end
      tdp_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_d = div_status.rem_zero ? tdp_pkg::ST_FINISH : tdp_pkg::ST_CHECK;
        end
      end
      tdp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = tdp_pkg::ST_IDLE;
        end
      end
      default: state_d = tdp_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o  = 1'b0;
    div_start   = 1'b0;
    finish_load = 1'b0;
    unique case (state_q)
      tdp_pkg::ST_IDLE:   in_ready_o  = 1'b1;
      tdp_pkg::ST_CHECK:  div_start   = in_bound;
      tdp_pkg::ST_DIV:    ;
      tdp_pkg::ST_FINISH: finish_load = out_free;
      default:            ;
    endcase
  end

  // Datapath
  always_comb begin
    n_d         = n_q;
    d_d         = d_q;
    sq_d        = sq_q;
    res_d       = res_q;
    out_prime_d = out_prime_q;
    out_valid_d = out_valid_q;

    if (in_accept) begin
      n_d   = value_i[tdp_pkg::MagWidth-1:0];
      d_d   = tdp_pkg::DivWidth'(tdp_pkg::FirstDivisor);
      sq_d  = tdp_pkg::SqWidth'(tdp_pkg::FirstDivisor * tdp_pkg::FirstDivisor);
      res_d = !too_small;
    end

    if ((state_q == tdp_pkg::ST_DIV) && div_status.done) begin
      if (div_status.rem_zero) begin
        res_d = 1'b0;
      end else begin
        // advance: (d+1)^2 = d^2 + 2d + 1
        d_d  = d_q + 1'b1;
        sq_d = sq_q + tdp_pkg::SqWidth'({d_q, 1'b1});
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish_load) begin
      out_valid_d = 1'b1;
      out_prime_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    res_q       <= res_d;
    out_prime_q <= out_prime_d;
  end

  tdp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .status_o   (div_status)
  );

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_prime_q;

`include "trial_division_prime_test_assert.svh"

  `TDP_ASSERT_IMPL(a_done_only_in_div, clk_i, rst_ni, div_status.done,
                   state_q == tdp_pkg::ST_DIV, "remainder done outside divide state")
  `TDP_ASSERT_IMPL(a_divisor_min, clk_i, rst_ni, state_q == tdp_pkg::ST_CHECK,
                   d_q >= tdp_pkg::DivWidth'(tdp_pkg::FirstDivisor), "trial divisor below two")
  `TDP_ASSERT_NEXT(a_finish_loads, clk_i, rst_ni, finish_load,
                   out_valid_q && (is_prime_o == $past(res_q)), "result not loaded at finish")
  `TDP_ASSERT_IMPL(a_composite_in_bound, clk_i, rst_ni,
                   (state_q == tdp_pkg::ST_DIV) && div_status.done && div_status.rem_zero,
                   res_q, "factor found after item already resolved")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
module tb_top;

  localparam int          NumDirected   = 19;
  localparam int          NumRandom     = 100;
  // The largest positive prime is the slowest word to finish on its own.
  localparam int unsigned WatchdogLimit = 8_000_000;
  localparam int          DrainCycles   = 50;

  typedef struct packed {
    logic [tdp_pkg::NumWidth-1:0] value;
    logic                         known;
    logic                         prime;
  } stim_row_t;

  typedef struct packed {
    logic [tdp_pkg::NumWidth-1:0] value;
    logic                         prime;
  } primality_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [tdp_pkg::NumWidth-1:0] value_i;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         is_prime_o;

  primality_t  pending_primality_q[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;

  // Rows with known = 1 carry the answer; the rest go through the predictor.
  stim_row_t directed_rows [NumDirected] = '{
    '{32'h0000_0000, 1'b1, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b0},
    '{32'h0000_0002, 1'b1, 1'b1},
    '{32'h0000_0003, 1'b1, 1'b1},
    '{32'h0000_0004, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b0},
    '{32'hFFFF_FFFE, 1'b1, 1'b0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0},
    '{32'h7FFF_FFFE, 1'b1, 1'b0},
    '{32'h0000_0005, 1'b0, 1'b0},
    '{32'h0000_0009, 1'b0, 1'b0},
    '{32'h0000_0019, 1'b0, 1'b0},
    '{32'h0000_0079, 1'b0, 1'b0},
    '{32'h0000_0061, 1'b0, 1'b0},
    '{32'h0000_FFFF, 1'b0, 1'b0},
    '{32'h0001_0001, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1}
  };

  trial_division_prime_test DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_prime_o  (is_prime_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic predict_prime(logic [tdp_pkg::NumWidth-1:0] value);
    longint unsigned n;
    longint unsigned d;
    if (value[tdp_pkg::NumWidth-1]) return 1'b0;
    n = longint'(value);
    if (n < 2) return 1'b0;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Keep most words cheap: small and mid-sized values, negatives, and large
  // values that carry a small factor.
  function automatic logic [tdp_pkg::NumWidth-1:0] pick_value();
    int unsigned     sel;
    longint unsigned factor;
    longint unsigned mult;
    logic [31:0]     bits;
    sel  = $urandom_range(0, 99);
    bits = $urandom();
    if (sel < 40) return tdp_pkg::NumWidth'($urandom_range(0, 4096));
    if (sel < 55) return tdp_pkg::NumWidth'($urandom_range(4097, 1 << 20));
    if (sel < 70) return {1'b1, bits[30:0]};
    if (sel < 85) return {1'b0, bits[30:1], 1'b0};
    factor = $urandom_range(3, 97);
    mult   = $urandom_range(1, int'(32'h7FFF_FFFF / factor));
    return tdp_pkg::NumWidth'(factor * mult);
  endfunction

  // Sender: bursts of words with random gaps between them.
  initial begin
    int          idx;
    int          burst_left;
    int          gap;
    stim_row_t   row;
    primality_t  expect_item;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    burst_left  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (idx = 0; idx < NumDirected + NumRandom; idx++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 8);
      end
      if (idx < NumDirected) begin
        row = directed_rows[idx];
      end else begin
        row = '{pick_value(), 1'b0, 1'b0};
      end
      value_i    = row.value;
      in_valid_i = 1'b1;
      do @(posedge clk_i); while (!in_ready_o);
      expect_item.value = row.value;
      expect_item.prime = row.known ? row.prime : predict_prime(row.value);
      pending_primality_q.push_back(expect_item);
      burst_left--;
      @(negedge clk_i);
    end
    in_valid_i = 1'b0;
    while (pending_primality_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** trial_division_prime_test: PASSED **");
    end else begin
      $display("** trial_division_prime_test: FAILED **");
    end
    $finish;
  end

  // Receiver: switch between always ready, light stalls and heavy stalls.
  always @(negedge clk_i) begin
    static int run_left = 0;
    static int mode     = 0;
    if (run_left == 0) begin
      mode     = $urandom_range(0, 2);
      run_left = $urandom_range(20, 300);
    end
    run_left--;
    case (mode)
      0: out_ready_i = 1'b1;
      1: out_ready_i = ($urandom_range(0, 1) == 1);
      default: out_ready_i = ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    primality_t expect_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_primality_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("ERROR: result word is_prime=%0b with none expected", is_prime_o);
        end
      end else begin
        expect_item = pending_primality_q.pop_front();
        if (is_prime_o !== expect_item.prime) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: value 0x%08h: is_prime expected %0b, got %0b",
                     expect_item.value, expect_item.prime, is_prime_o);
          end
        end
      end
    end
  end

  // Reset the count on any word moved on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("ERROR: no word moved for %0d cycles", WatchdogLimit);
        $display("** trial_division_prime_test: FAILED **");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tdp_pkg.sv
rtl/tdp_div.sv
rtl/trial_division_prime_test.sv
dv/tb_top.sv
